FILE: rtl/tac_pkg.sv
// ---------------------------------------------------------------------------
// Autotile classifier package
// Shared widths, codes and interface types of the autotile classifier.
// ---------------------------------------------------------------------------
`default_nettype none

package tac_pkg;

	// Grid limits; MAX_COLS is a power of two so that a cell address is
	// simply {row, col}.
	localparam int MAX_ROWS = 64;
	localparam int MAX_COLS = 64;
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ADDR_W   = ROW_W + COL_W;
	localparam int DEPTH    = MAX_ROWS * MAX_COLS;

	// Width of the grid size registers.
	localparam int DIM_W    = 7;

	// Width of the tile sheet coordinates.
	localparam int TILE_W   = 4;

	// Item kinds.
	localparam logic OP_WRITE    = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// Configuration register indexes.
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Request to the grid memory.
	typedef struct packed {
		logic              en;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic              wdata;
	} ram_req_t;

	// Chosen tile on the sheet.
	typedef struct packed {
		logic [TILE_W-1:0] trow;
		logic [TILE_W-1:0] tcol;
	} tile_t;

	// One result beat.
	typedef struct packed {
		logic              out_of_range;
		logic [7:0]        neighbour_mask;
		logic [TILE_W-1:0] sheet_row;
		logic [TILE_W-1:0] sheet_col;
		logic              is_wall;
	} res_t;

endpackage : tac_pkg

`default_nettype wire

FILE: rtl/tac_grid_ram.sv
// ---------------------------------------------------------------------------
// Autotile grid memory
// Single-port one-bit cell store with a registered read, one access a cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module tac_grid_ram (
	input  wire logic              clk,
	input  wire tac_pkg::ram_req_t req,
	output logic                   rdata
);
	import tac_pkg::*;

	logic cells [DEPTH];

	// Contents are undefined until written, so the array has no reset.
	always_ff @(posedge clk) begin
		if (req.en) begin
			if (req.we) begin
				cells[req.addr] <= req.wdata;
			end else begin
				rdata <= cells[req.addr];
			end
		end
	end

endmodule : tac_grid_ram

`default_nettype wire

FILE: rtl/tac_tile_lut.sv
// ---------------------------------------------------------------------------
// Autotile blob rule lookup
// Maps an eight-neighbour wall mask to a tile sheet position; the last
// matching rule wins. The answer is registered.
// ---------------------------------------------------------------------------
`default_nettype none

module tac_tile_lut (
	input  wire logic           clk,
	input  wire logic [7:0]     mask,
	output tac_pkg::tile_t      tile_s2
);
	import tac_pkg::*;

	typedef struct packed {
		logic [7:0]        clr;
		logic [7:0]        set;
		logic [TILE_W-1:0] tcol;
		logic [TILE_W-1:0] trow;
	} rule_t;

	// Neighbour bits: 1 top-left, 2 top, 3 top-right, 4 left, 5 right,
	// 6 bottom-left, 7 bottom, 8 bottom-right.
	localparam logic [7:0] N1 = 8'h01;
	localparam logic [7:0] N2 = 8'h02;
	localparam logic [7:0] N3 = 8'h04;
	localparam logic [7:0] N4 = 8'h08;
	localparam logic [7:0] N5 = 8'h10;
	localparam logic [7:0] N6 = 8'h20;
	localparam logic [7:0] N7 = 8'h40;
	localparam logic [7:0] N8 = 8'h80;
	localparam logic [7:0] ED = N2 | N4 | N5 | N7;
	localparam logic [7:0] CO = N1 | N3 | N6 | N8;

	localparam int NUM_RULES = 47;

	localparam rule_t RULES [NUM_RULES] = '{
		'{ED, 8'h00, 4'd6, 4'd7},
		'{N2 | N4 | N5, N7, 4'd5, 4'd5},
		'{N2 | N4 | N7, N5, 4'd6, 4'd5},
		'{N2 | N5 | N7, N4, 4'd5, 4'd4},
		'{N4 | N5 | N7, N2, 4'd6, 4'd4},
		'{N2 | N7, N4 | N5, 4'd2, 4'd4},
		'{N4 | N5, N2 | N7, 4'd2, 4'd5},
		'{N2 | N4, N5 | N7 | N8, 4'd7, 4'd4},
		'{N2 | N5, N4 | N7 | N6, 4'd8, 4'd4},
		'{N4 | N7, N2 | N5 | N3, 4'd7, 4'd5},
		'{N5 | N7, N2 | N4 | N1, 4'd8, 4'd5},
		'{N2 | N4 | N8, N5 | N7, 4'd0, 4'd4},
		'{N2 | N5 | N6, N4 | N7, 4'd1, 4'd4},
		'{N4 | N7 | N3, N2 | N5, 4'd0, 4'd5},
		'{N5 | N7 | N1, N2 | N4, 4'd1, 4'd5},
		'{N2 | N6 | N8, N4 | N5 | N7, 4'd3, 4'd4},
		'{N4 | N3 | N8, N2 | N5 | N7, 4'd3, 4'd5},
		'{N5 | N1 | N6, N2 | N4 | N7, 4'd4, 4'd5},
		'{N7 | N1 | N3, N2 | N4 | N5, 4'd4, 4'd4},
		'{N2 | N6, N4 | N5 | N7 | N8, 4'd4, 4'd8},
		'{N4 | N3, N2 | N5 | N7 | N8, 4'd2, 4'd8},
		'{N5 | N1, N2 | N4 | N7 | N6, 4'd3, 4'd8},
		'{N7 | N1, N2 | N4 | N5 | N3, 4'd4, 4'd9},
		'{N2 | N8, N4 | N5 | N7 | N6, 4'd5, 4'd8},
		'{N4 | N8, N2 | N5 | N7 | N3, 4'd2, 4'd9},
		'{N5 | N6, N2 | N4 | N7 | N1, 4'd3, 4'd9},
		'{N7 | N3, N2 | N4 | N5 | N1, 4'd5, 4'd9},
		'{N2, N4 | N5 | N7 | N6 | N8, 4'd4, 4'd7},
		'{N4, N2 | N5 | N7 | N3 | N8, 4'd4, 4'd6},
		'{N5, N2 | N4 | N7 | N1 | N6, 4'd5, 4'd6},
		'{N7, N2 | N4 | N5 | N1 | N3, 4'd5, 4'd7},
		'{CO, ED, 4'd7, 4'd6},
		'{N1 | N3 | N6, ED | N8, 4'd0, 4'd8},
		'{N1 | N3 | N8, ED | N6, 4'd1, 4'd8},
		'{N1 | N6 | N8, ED | N3, 4'd0, 4'd9},
		'{N3 | N6 | N8, ED | N1, 4'd1, 4'd9},
		'{N1 | N3, ED | N6 | N8, 4'd3, 4'd6},
		'{N1 | N6, ED | N3 | N8, 4'd3, 4'd7},
		'{N1 | N8, ED | N3 | N6, 4'd6, 4'd9},
		'{N3 | N6, ED | N1 | N8, 4'd6, 4'd8},
		'{N3 | N8, ED | N1 | N6, 4'd2, 4'd7},
		'{N6 | N8, ED | N1 | N3, 4'd2, 4'd6},
		'{N1, ED | N3 | N6 | N8, 4'd1, 4'd7},
		'{N3, ED | N1 | N6 | N8, 4'd0, 4'd7},
		'{N6, ED | N1 | N3 | N8, 4'd1, 4'd6},
		'{N8, ED | N1 | N3 | N6, 4'd0, 4'd6},
		'{8'h00, ED | CO, 4'd6, 4'd6}
	};

	tile_t tile_d;

	// Every rule is matched in parallel; later rules override earlier ones.
	always_comb begin
		tile_d = '0;
		for (int k = 0; k < NUM_RULES; k++) begin
			if (((mask & RULES[k].clr) == 8'h00) &&
			    ((mask & RULES[k].set) == RULES[k].set)) begin
				tile_d.tcol = RULES[k].tcol;
				tile_d.trow = RULES[k].trow;
			end
		end
	end

	always_ff @(posedge clk) begin
		tile_s2 <= tile_d;
	end

endmodule : tac_tile_lut

`default_nettype wire

FILE: rtl/tac_seq.sv
// ---------------------------------------------------------------------------
// Autotile sequencer
// Holds the grid size, takes items, drives the grid memory one access a
// cycle, gathers the neighbour mask and presents the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module tac_seq (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic                         cfg_index,
	input  wire logic [tac_pkg::DIM_W-1:0]    cfg_data,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         in_op,
	input  wire logic [tac_pkg::ROW_W-1:0]    in_row,
	input  wire logic [tac_pkg::COL_W-1:0]    in_col,
	input  wire logic                         in_value,
	output tac_pkg::ram_req_t                 ram_req,
	input  wire logic                         ram_rdata,
	output logic [7:0]                        lut_mask,
	input  wire tac_pkg::tile_t               lut_tile,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output tac_pkg::res_t                     out_res
);
	import tac_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_READ  = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_LOOK  = 3'd3;
	localparam logic [2:0] S_PACK  = 3'd4;
	localparam logic [2:0] S_EMIT  = 3'd5;

	// Read positions: centre first, then the neighbours in mask order.
	localparam logic [3:0] POS_CENTRE = 4'd0;
	localparam logic [3:0] POS_LAST   = 4'd8;

	logic [2:0]       state_q;
	logic [DIM_W-1:0] grid_rows_q;
	logic [DIM_W-1:0] grid_cols_q;
	logic [DIM_W-1:0] rows_use;
	logic [DIM_W-1:0] cols_use;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [3:0]       cnt_q;
	logic             rd_vld_s1;
	logic             rd_in_s1;
	logic [3:0]       rd_pos_s1;
	logic [3:0]       pos_m1;
	logic             wall_q;
	logic [7:0]       nbr_q;
	res_t             res_q;
	logic             accept;
	logic             in_range;
	logic [DIM_W-1:0] dr;
	logic [DIM_W-1:0] dc;
	logic [DIM_W-1:0] nr;
	logic [DIM_W-1:0] nc;
	logic             nb_in_grid;
	logic             out_free;
	logic             cap_bit;

	// Sizes above the maximum saturate; zero leaves every cell outside.
	assign rows_use = (grid_rows_q > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : grid_rows_q;
	assign cols_use = (grid_cols_q > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : grid_cols_q;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign in_range = (DIM_W'(in_row) < rows_use) && (DIM_W'(in_col) < cols_use);
	assign out_free = !out_valid || out_ready;

	// Row and column offsets of the position being read; minus one wraps to
	// a large value and so falls outside the grid.
	always_comb begin
		dr = '0;
		dc = '0;
		case (cnt_q)
			4'd1: begin dr = '1;          dc = '1;          end
			4'd2: begin dr = '1;          dc = '0;          end
			4'd3: begin dr = '1;          dc = DIM_W'(1);   end
			4'd4: begin dr = '0;          dc = '1;          end
			4'd5: begin dr = '0;          dc = DIM_W'(1);   end
			4'd6: begin dr = DIM_W'(1);   dc = '1;          end
			4'd7: begin dr = DIM_W'(1);   dc = '0;          end
			4'd8: begin dr = DIM_W'(1);   dc = DIM_W'(1);   end
			default: begin dr = '0;       dc = '0;          end
		endcase
	end

	assign nr         = DIM_W'(row_q) + dr;
	assign nc         = DIM_W'(col_q) + dc;
	assign nb_in_grid = (nr < rows_use) && (nc < cols_use);

	// Memory port: writes at accept, neighbourhood reads while sweeping.
	always_comb begin
		ram_req = '0;
		if (state_q == S_IDLE) begin
			ram_req.en    = accept && in_range && (in_op == OP_WRITE);
			ram_req.we    = 1'b1;
			ram_req.addr  = {in_row, in_col};
			ram_req.wdata = in_value;
		end else if (state_q == S_READ) begin
			ram_req.en    = nb_in_grid;
			ram_req.we    = 1'b0;
			ram_req.addr  = {nr[ROW_W-1:0], nc[COL_W-1:0]};
			ram_req.wdata = 1'b0;
		end
	end

	// A floor centre yields an empty mask.
	assign lut_mask = wall_q ? nbr_q : 8'h00;
	assign pos_m1   = rd_pos_s1 - 4'd1;
	assign cap_bit  = rd_in_s1 && ram_rdata;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			grid_rows_q <= DIM_W'(15);
			grid_cols_q <= DIM_W'(20);
			cnt_q       <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_ROWS: grid_rows_q <= cfg_data;
					REG_COLS: grid_cols_q <= cfg_data;
					default:  grid_rows_q <= grid_rows_q;
				endcase
			end
			rd_vld_s1 <= (state_q == S_READ);
			if ((state_q == S_EMIT) && out_free) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cnt_q <= POS_CENTRE;
						if (in_range && (in_op == OP_CLASSIFY)) begin
							state_q <= S_READ;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_READ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == POS_LAST) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_LOOK;
				S_LOOK:  state_q <= S_PACK;
				S_PACK:  state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			row_q <= in_row;
			col_q <= in_col;
			res_q <= '{
				out_of_range:   !in_range,
				neighbour_mask: 8'h00,
				sheet_row:      TILE_W'(0),
				sheet_col:      TILE_W'(0),
				is_wall:        1'b0
			};
		end
		if (state_q == S_READ) begin
			rd_pos_s1 <= cnt_q;
			rd_in_s1  <= nb_in_grid;
		end
		// Capture the read issued in the previous cycle.
		if (rd_vld_s1) begin
			if (rd_pos_s1 == POS_CENTRE) begin
				wall_q <= cap_bit;
			end else begin
				nbr_q[pos_m1[2:0]] <= cap_bit;
			end
		end
		if (state_q == S_PACK) begin
			res_q <= '{
				out_of_range:   1'b0,
				neighbour_mask: lut_mask,
				sheet_row:      wall_q ? lut_tile.trow : TILE_W'(0),
				sheet_col:      wall_q ? lut_tile.tcol : TILE_W'(0),
				is_wall:        wall_q
			};
		end
		if ((state_q == S_EMIT) && out_free) begin
			out_res <= res_q;
		end
	end

endmodule : tac_seq

`default_nettype wire

FILE: rtl/tile_autotile_classifier.sv
// ---------------------------------------------------------------------------
// Autotile classifier
// Wall/floor grid with blob autotiling: write beats store one cell, classify
// beats return the eight-neighbour mask and the tile sheet position.
// ---------------------------------------------------------------------------
//
//  Channel    Direction  Contents
//  s_axis     in         tuser: opcode; tdata: row, col, cell_value
//  m_axis     out        tdata: is_wall, sheet_col, sheet_row, mask, out_of_range
//  cfg        in         cfg_we, cfg_index (0 rows, 1 cols), cfg_data
//
//  A write or out-of-range beat goes from the idle step to the emit step, which
//  loads the result register; the next beat is taken back in the idle step.
//  A classify beat passes through nine reads of the single-port grid memory,
//  one per cycle, then capture, rule lookup, result packing and the emit step,
//  after which the next beat can be taken.
//  One beat is in work at a time; the next is taken while a result still waits.
//  A stalled result holds the sequencer in its emit step until taken.
//  Reset restores the grid size to 15 rows by 20 columns; the grid is not cleared.
//
`default_nettype none

module tile_autotile_classifier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [6:0]  cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // row[5:0], col[11:6], cell_value[12]
	input  wire logic        s_tuser,   // opcode[0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [23:0]      m_tdata    // is_wall[0], sheet_col[4:1], sheet_row[8:5],
	                                    // neighbour_mask[16:9], out_of_range[17]
);
	import tac_pkg::*;

	ram_req_t   ram_req;
	logic       ram_rdata;
	logic [7:0] lut_mask;
	tile_t      lut_tile;
	res_t       res;

	tac_grid_ram u_ram (
		.clk   (clk),
		.req   (ram_req),
		.rdata (ram_rdata)
	);

	tac_tile_lut u_lut (
		.clk     (clk),
		.mask    (lut_mask),
		.tile_s2 (lut_tile)
	);

	tac_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_row    (s_tdata[ROW_W-1:0]),
		.in_col    (s_tdata[ROW_W+COL_W-1:ROW_W]),
		.in_value  (s_tdata[ROW_W+COL_W]),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.lut_mask  (lut_mask),
		.lut_tile  (lut_tile),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (res)
	);

	// Result fields packed from the lowest bit up.
	assign m_tdata = {6'b0, res};

	// An out-of-range result carries nothing else.
	a_oor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[17] |-> m_tdata[16:0] == 17'd0)
		else $error("out-of-range result carries data");

	// A floor result has neither mask nor tile.
	a_floor_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[0] |-> m_tdata[16:1] == 16'd0)
		else $error("floor result carries mask or tile");

	// Only one beat is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second beat taken while one is in work");

endmodule : tile_autotile_classifier

`default_nettype wire
